// ----- rtl/ddo_pkg.sv -----
package ddo_pkg;

  // rotation and position sizing
  localparam int unsigned CORDIC_STEPS   = 20;
  localparam int unsigned POSITION_WIDTH = 32;

  // arctangent table size and step counter width
  localparam int unsigned ATAN_LEN   = 30;
  localparam int unsigned ATAN_IDX_W = 5;
  localparam int unsigned STEP_W     = $clog2(CORDIC_STEPS);

  // datapath widths: travel magnitude, rotated vector, residual angle
  localparam int unsigned TRAV_W = 48;
  localparam int unsigned VEC_W  = 50;
  localparam int unsigned Z_W    = 34;
  localparam int unsigned SUM_W  = ((POSITION_WIDTH > VEC_W) ? POSITION_WIDTH : VEC_W) + 1;

  // apb address width for two word registers
  localparam int unsigned ADDR_W = 3;

  // cordic gain inverse, unsigned q0.32
  localparam logic [31:0] GAIN_INV = 32'h9B74_EDA8;

  // register reset values
  localparam logic [31:0] DIST_RESET = 32'd293178;
  localparam logic [31:0] HEAD_RESET = 32'd141397;

  // saturation limits
  localparam logic signed [SUM_W-1:0] POS_MAX =
    {{(SUM_W-POSITION_WIDTH+1){1'b0}}, {(POSITION_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] POS_MIN = ~POS_MAX;
  localparam logic signed [SUM_W-1:0] OUT_MAX = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SUM_W-1:0] OUT_MIN = ~OUT_MAX;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_DIST = 1'b0,
    REG_HEAD = 1'b1
  } reg_idx_e;

  // configuration seen by the datapath
  typedef struct packed {
    logic [31:0] dist_per_tick;
    logic [31:0] heading_per_tick;
  } cfg_t;

  // arctangent of 2^-i in binary angle units
  function automatic logic [31:0] atan_lookup(logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'h2000_0000;
      5'd1:    val = 32'h12E4_051E;
      5'd2:    val = 32'h09FB_385B;
      5'd3:    val = 32'h0511_11D4;
      5'd4:    val = 32'h028B_0D43;
      5'd5:    val = 32'h0145_D7E1;
      5'd6:    val = 32'h00A2_F61E;
      5'd7:    val = 32'h0051_7C55;
      5'd8:    val = 32'h0028_BE53;
      5'd9:    val = 32'h0014_5F2F;
      5'd10:   val = 32'h000A_2F98;
      5'd11:   val = 32'h0005_17CC;
      5'd12:   val = 32'h0002_8BE6;
      5'd13:   val = 32'h0001_45F3;
      5'd14:   val = 32'h0000_A2FA;
      5'd15:   val = 32'h0000_517D;
      5'd16:   val = 32'h0000_28BE;
      5'd17:   val = 32'h0000_145F;
      5'd18:   val = 32'h0000_0A30;
      5'd19:   val = 32'h0000_0518;
      5'd20:   val = 32'h0000_028C;
      5'd21:   val = 32'h0000_0146;
      5'd22:   val = 32'h0000_00A3;
      5'd23:   val = 32'h0000_0051;
      5'd24:   val = 32'h0000_0029;
      5'd25:   val = 32'h0000_0014;
      5'd26:   val = 32'h0000_000A;
      5'd27:   val = 32'h0000_0005;
      5'd28:   val = 32'h0000_0003;
      5'd29:   val = 32'h0000_0001;
      default: val = 32'h0000_0000;
    endcase
    return val;
  endfunction

  // clamp a wide sum to the position accumulator range
  function automatic logic signed [POSITION_WIDTH-1:0] sat_pos(logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    if (v > POS_MAX) begin
      r = POS_MAX;
    end else if (v < POS_MIN) begin
      r = POS_MIN;
    end else begin
      r = v;
    end
    return r[POSITION_WIDTH-1:0];
  endfunction

  // clamp a wide value to the 32-bit output range
  function automatic logic signed [31:0] sat_out(logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    if (v > OUT_MAX) begin
      r = OUT_MAX;
    end else if (v < OUT_MIN) begin
      r = OUT_MIN;
    end else begin
      r = v;
    end
    return r[31:0];
  endfunction

endpackage

// ----- rtl/diff_drive_odometry.sv -----
// channel   direction  transfer when            payload
// config    in         psel&penable&pwrite      paddr, pwdata (prdata on read)
// input     in         in_valid_i&in_ready_o    right_ticks_i, left_ticks_i
// result    out        out_valid_o&out_ready_i  pos_x_o, pos_y_o, heading_o
//
// an item passes from transfer to result valid through four products on the
// shared 32x32 multiplier, then the iterative cordic rotator, then the
// accumulate step for the pose.
// in_ready_o is high only while the sequencer idles; a result waits in the
// output register and the next item is taken meanwhile, but its accumulate
// step holds until the previous result is transferred.
// reset clears pose, last counts and registers to their defaults.
module diff_drive_odometry (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ddo_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [31:0]         right_ticks_i,
  input  logic signed [31:0]         left_ticks_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [31:0]         pos_x_o,
  output logic signed [31:0]         pos_y_o,
  output logic [31:0]                heading_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MUL_T  = 8'b0000_0010,
    S_TRAV   = 8'b0000_0100,
    S_MUL_LO = 8'b0000_1000,
    S_MUL_HI = 8'b0001_0000,
    S_LOAD   = 8'b0010_0000,
    S_ROT    = 8'b0100_0000,
    S_ACC    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  ddo_pkg::cfg_t cfg;

  logic [31:0] last_right_q, last_left_q;
  logic signed [ddo_pkg::POSITION_WIDTH-1:0] acc_x_q, acc_y_q, acc_x_d, acc_y_d;
  logic [31:0] acc_heading_q, acc_heading_d;

  logic [32:0] mag_q;
  logic        neg_q;
  logic [31:0] diff_q, dh_q, lohi_q;
  logic [46:0] travel_q;

  logic [31:0] dr, dl;
  logic [32:0] tick_sum, tick_mag;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod, t_full;

  logic [ddo_pkg::TRAV_W-1:0]       trav;
  logic [ddo_pkg::VEC_W-1:0]        trav_ext;
  logic                             fold, negx;
  logic signed [ddo_pkg::VEC_W-1:0] cx0, cx, cy;
  logic signed [ddo_pkg::Z_W-1:0]   cz0;
  logic                             cordic_done;

  logic signed [ddo_pkg::SUM_W-1:0] sum_x, sum_y, wide_x, wide_y;

  logic in_fire, acc_fire;
  logic out_valid_q;
  logic signed [31:0] pos_x_q, pos_y_q;
  logic [31:0] heading_q;

  ddo_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // tick deltas against the previous counts, wrapping
  assign dr       = unsigned'(right_ticks_i) - last_right_q;
  assign dl       = unsigned'(left_ticks_i) - last_left_q;
  assign tick_sum = {dr[31], dr} + {dl[31], dl};
  assign tick_mag = tick_sum[32] ? (~tick_sum + 33'd1) : tick_sum;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign acc_fire   = (state_q == S_ACC) && (!out_valid_q || out_ready_i);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MUL_T: begin
        mul_a = mag_q[31:0];
        mul_b = cfg.dist_per_tick;
      end
      S_TRAV: begin
        mul_a = diff_q;
        mul_b = cfg.heading_per_tick;
      end
      S_MUL_LO: begin
        mul_a = travel_q[31:0];
        mul_b = ddo_pkg::GAIN_INV;
      end
      S_MUL_HI: begin
        mul_a = {17'd0, travel_q[46:32]};
        mul_b = ddo_pkg::GAIN_INV;
      end
      S_IDLE, S_LOAD, S_ROT, S_ACC: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ddo_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // magnitude of exactly 2^32 carries one extra term
  assign t_full = prod + (mag_q[32] ? {cfg.dist_per_tick, 32'd0} : 64'd0);

  // gain-scaled travel, sign and half-turn fold for the cordic start
  assign trav     = prod[ddo_pkg::TRAV_W-1:0] + {{(ddo_pkg::TRAV_W-32){1'b0}}, lohi_q};
  assign trav_ext = {{(ddo_pkg::VEC_W-ddo_pkg::TRAV_W){1'b0}}, trav};
  assign fold     = acc_heading_q[31] ^ acc_heading_q[30];
  assign negx     = neg_q ^ fold;
  assign cx0      = negx ? -signed'(trav_ext) : signed'(trav_ext);
  assign cz0      = signed'({{(ddo_pkg::Z_W-31){acc_heading_q[30]}}, acc_heading_q[30:0]});

  ddo_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_LOAD),
    .x0_i    (cx0),
    .z0_i    (cz0),
    .done_o  (cordic_done),
    .x_o     (cx),
    .y_o     (cy)
  );

  // pose update with saturation
  assign sum_x = signed'({{(ddo_pkg::SUM_W-ddo_pkg::POSITION_WIDTH){acc_x_q[ddo_pkg::POSITION_WIDTH-1]}},
                 acc_x_q}) + signed'({{(ddo_pkg::SUM_W-ddo_pkg::VEC_W){cx[ddo_pkg::VEC_W-1]}}, cx});
  assign sum_y = signed'({{(ddo_pkg::SUM_W-ddo_pkg::POSITION_WIDTH){acc_y_q[ddo_pkg::POSITION_WIDTH-1]}},
                 acc_y_q}) + signed'({{(ddo_pkg::SUM_W-ddo_pkg::VEC_W){cy[ddo_pkg::VEC_W-1]}}, cy});
  assign acc_x_d = ddo_pkg::sat_pos(sum_x);
  assign acc_y_d = ddo_pkg::sat_pos(sum_y);
  assign wide_x  = signed'({{(ddo_pkg::SUM_W-ddo_pkg::POSITION_WIDTH){acc_x_d[ddo_pkg::POSITION_WIDTH-1]}},
                   acc_x_d});
  assign wide_y  = signed'({{(ddo_pkg::SUM_W-ddo_pkg::POSITION_WIDTH){acc_y_d[ddo_pkg::POSITION_WIDTH-1]}},
                   acc_y_d});
  assign acc_heading_d = acc_heading_q + dh_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_fire) state_d = S_MUL_T;
      S_MUL_T:  state_d = S_TRAV;
      S_TRAV:   state_d = S_MUL_LO;
      S_MUL_LO: state_d = S_MUL_HI;
      S_MUL_HI: state_d = S_LOAD;
      S_LOAD:   state_d = S_ROT;
      S_ROT:    if (cordic_done) state_d = S_ACC;
      S_ACC:    if (acc_fire) state_d = S_IDLE;
    endcase
  end

  // control and pose state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      last_right_q  <= '0;
      last_left_q   <= '0;
      acc_x_q       <= '0;
      acc_y_q       <= '0;
      acc_heading_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        last_right_q <= unsigned'(right_ticks_i);
        last_left_q  <= unsigned'(left_ticks_i);
      end
      if (acc_fire) begin
        acc_x_q       <= acc_x_d;
        acc_y_q       <= acc_y_d;
        acc_heading_q <= acc_heading_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mag_q  <= tick_mag;
      neg_q  <= tick_sum[32];
      diff_q <= dr - dl;
    end
    if (state_q == S_TRAV) begin
      travel_q <= t_full[63:17];
    end
    if (state_q == S_MUL_LO) begin
      dh_q <= prod[31:0];
    end
    if (state_q == S_MUL_HI) begin
      lohi_q <= prod[63:32];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (acc_fire) begin
      pos_x_q   <= ddo_pkg::sat_out(wide_x);
      pos_y_q   <= ddo_pkg::sat_out(wide_y);
      heading_q <= acc_heading_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign heading_o   = heading_q;

endmodule

// ----- rtl/ddo_apb_regs.sv -----
module ddo_apb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ddo_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output ddo_pkg::cfg_t              cfg_o
);

  logic [31:0]       dist_q;
  logic [31:0]       head_q;
  logic              wr_en;
  ddo_pkg::reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = ddo_pkg::reg_idx_e'(paddr[2]);

  // register write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= ddo_pkg::DIST_RESET;
      head_q <= ddo_pkg::HEAD_RESET;
    end else if (wr_en) begin
      unique case (idx)
        ddo_pkg::REG_DIST: dist_q <= pwdata;
        ddo_pkg::REG_HEAD: head_q <= pwdata;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      ddo_pkg::REG_DIST: prdata = dist_q;
      ddo_pkg::REG_HEAD: prdata = head_q;
    endcase
  end

  assign cfg_o.dist_per_tick    = dist_q;
  assign cfg_o.heading_per_tick = head_q;

endmodule

// ----- rtl/ddo_mul.sv -----
module ddo_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  // shared unsigned multiplier, product registered
  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

// ----- rtl/ddo_cordic.sv -----
module ddo_cordic (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [ddo_pkg::VEC_W-1:0] x0_i,
  input  logic signed [ddo_pkg::Z_W-1:0]   z0_i,
  output logic                             done_o,
  output logic signed [ddo_pkg::VEC_W-1:0] x_o,
  output logic signed [ddo_pkg::VEC_W-1:0] y_o
);

  logic                             busy_q;
  logic                             done_q;
  logic [ddo_pkg::STEP_W-1:0]       cnt_q;
  logic signed [ddo_pkg::VEC_W-1:0] x_q, y_q, x_d, y_d, xs, ys;
  logic signed [ddo_pkg::Z_W-1:0]   z_q, z_d, atan_s;
  logic                             last_step;

  // shifted operands and the step's arctangent
  assign xs        = x_q >>> cnt_q;
  assign ys        = y_q >>> cnt_q;
  assign atan_s    = signed'({{(ddo_pkg::Z_W-32){1'b0}},
                     ddo_pkg::atan_lookup(ddo_pkg::ATAN_IDX_W'(cnt_q))});
  assign last_step = (cnt_q == ddo_pkg::STEP_W'(ddo_pkg::CORDIC_STEPS - 1));

  // one micro-rotation toward zero residual angle
  always_comb begin
    if (!z_q[ddo_pkg::Z_W-1]) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - atan_s;
    end else begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + atan_s;
    end
  end

  // step counter and done flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // vector and angle registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x0_i;
      y_q <= '0;
      z_q <= z0_i;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;

endmodule

// ----- rtl/ddo_checker.sv -----
module ddo_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] pos_x_o,
  input logic signed [31:0] pos_y_o,
  input logic [31:0]        heading_o
);

  // busy after an input transfer
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o)
    else $error("input taken while an item is in flight");

  // a new result appears only as the sequencer finishes
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised without work in flight");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(pos_x_o) && $stable(pos_y_o) && $stable(heading_o)))
    else $error("stalled result changed");

  // heading moves only together with a valid result
  a_heading_with_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (heading_o != $past(heading_o)) |-> out_valid_o)
    else $error("heading changed without a result");

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .pos_x_o     (pos_x_o),
  .pos_y_o     (pos_y_o),
  .heading_o   (heading_o)
);
